[design/aspect_fit_placement_core_defines.svh]
// Assertion macros shared by the placement core.
`ifndef ASPECT_FIT_PLACEMENT_CORE_DEFINES_SVH
`define ASPECT_FIT_PLACEMENT_CORE_DEFINES_SVH

// same-cycle implication
`define AFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/afp_pkg.sv]
// Types, constants and helpers for the aspect fit placement core.
package afp_pkg;

    localparam int SIZE_W   = 16;
    localparam int SRC_W    = 12;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam int NUM_W    = SIZE_W + SRC_W;
    localparam int DEN_W    = SRC_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [SIZE_W-1:0] MAX_REQ_WIDTH  = 16'd1920;
    localparam logic [SIZE_W-1:0] MAX_REQ_HEIGHT = 16'd1080;

    localparam logic [SRC_W-1:0] SRC_WIDTH_RESET  = 12'd1920;
    localparam logic [SRC_W-1:0] SRC_HEIGHT_RESET = 12'd1080;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZOOM_IN  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZOOM_OUT = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } afp_div_stat_t;

    // (frame - pic) / 2, truncated toward zero, low 16 bits
    function automatic logic [SIZE_W-1:0] half_slack(logic [SIZE_W-1:0] frame,
                                                     logic [SIZE_W-1:0] pic);
        logic signed [SIZE_W:0] diff;
        logic signed [SIZE_W:0] halved;
        diff   = $signed({1'b0, frame}) - $signed({1'b0, pic});
        halved = (diff + $signed({{SIZE_W{1'b0}}, diff[SIZE_W]})) >>> 1;
        return halved[SIZE_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] sat16(logic [NUM_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = (|v[NUM_W-1:SIZE_W]) ? {SIZE_W{1'b1}} : v[SIZE_W-1:0];
        return r;
    endfunction

endpackage

[design/afp_in_if.sv]
// Request channel: mode and requested encode size.
interface afp_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] req_width;
    logic [15:0] req_height;

    modport source (output valid, mode, req_width, req_height, input ready);
    modport sink   (input valid, mode, req_width, req_height, output ready);
endinterface

[design/afp_out_if.sv]
// Result channel: placement of the scaled picture in the encode frame.
interface afp_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] pic_width;
    logic        [15:0] pic_height;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic        [15:0] frame_width;
    logic        [15:0] frame_height;
    logic        [1:0]  status;
    logic               reencode;

    modport source (output valid, pic_width, pic_height, offset_x, offset_y,
                    frame_width, frame_height, status, reencode, input ready);
    modport sink   (input valid, pic_width, pic_height, offset_x, offset_y,
                    frame_width, frame_height, status, reencode, output ready);
endinterface

[design/afp_div.sv]
// Restoring divider, one quotient bit per cycle.
module afp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [afp_pkg::NUM_W-1:0]   num,
    input  logic [afp_pkg::DEN_W-1:0]   den,
    output logic [afp_pkg::NUM_W-1:0]   quot,
    output afp_pkg::afp_div_stat_t      stat
);
    import afp_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(NUM_W - 1);

    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in behind the numerator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign quot      = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[design/aspect_fit_placement_core.sv]
// Top level: sequencer, shared multiplier, placement state and channels.
//
//  channel   dir   handshake                  payload
//  request   in    request.valid/ready        mode, req_width, req_height
//  result    out   result.valid/ready         pic/frame size, offsets, status, reencode
//  cfg       in    cfg_wr_en (no wait)        cfg_index, cfg_data
//
// A request passes from accept to result through two multiply steps, a compare
// step, the restoring divider up to its done strobe, and a finish step.
// request.ready is high only while the sequencer is idle.
// A finished result sits in the output register; the next request is taken while
// it waits, and the finish step stalls only if the previous result is still held.
// Reset loads the default source size and clears the placement state.
`include "aspect_fit_placement_core_defines.svh"

module aspect_fit_placement_core (
    input  logic                            clk,
    input  logic                            rst_n,
    afp_in_if.sink                          request,
    afp_out_if.source                       result,
    input  logic                            cfg_wr_en,
    input  logic [afp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import afp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_CMP,
        S_DIV,
        S_FINISH
    } state_t;

    state_t state_reg;

    // configuration
    logic [SRC_W-1:0] src_width_reg;
    logic [SRC_W-1:0] src_height_reg;
    logic             stretch_reg;

    // latched request
    logic              mode_reg;
    logic [SIZE_W-1:0] w_reg;
    logic [SIZE_W-1:0] h_reg;

    logic [NUM_W-1:0]  prod_a_reg;
    logic [NUM_W-1:0]  prod_b_reg;
    logic              sel_b_reg;

    // placement state, also the result payload
    logic [SIZE_W-1:0]   pic_w_reg;
    logic [SIZE_W-1:0]   pic_h_reg;
    logic [SIZE_W-1:0]   off_x_reg;
    logic [SIZE_W-1:0]   off_y_reg;
    logic [SIZE_W-1:0]   frame_w_reg;
    logic [SIZE_W-1:0]   frame_h_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                reenc_reg;
    logic                out_valid_reg;

    logic [SRC_W-1:0]  sw;
    logic [SRC_W-1:0]  sh;
    logic [SIZE_W-1:0] sw16;
    logic [SIZE_W-1:0] sh16;

    logic [SIZE_W-1:0] mul_x;
    logic [SRC_W-1:0]  mul_y;
    logic [NUM_W-1:0]  prod;

    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [NUM_W-1:0]  div_quot;
    afp_div_stat_t     div_stat;

    logic both_ge;
    logic both_lt;
    logic mixed;
    logic sel_b_next;
    logic out_load;

    logic [SIZE_W-1:0]   q16;
    logic [SIZE_W-1:0]   pw;
    logic [SIZE_W-1:0]   ph;
    logic [SIZE_W-1:0]   pic_w_next;
    logic [SIZE_W-1:0]   pic_h_next;
    logic [SIZE_W-1:0]   off_x_next;
    logic [SIZE_W-1:0]   off_y_next;
    logic [SIZE_W-1:0]   frame_w_next;
    logic [SIZE_W-1:0]   frame_h_next;
    logic [STATUS_W-1:0] status_next;
    logic                reenc_next;

    // a zero source size counts as one
    assign sw   = (src_width_reg  == '0) ? SRC_W'(1) : src_width_reg;
    assign sh   = (src_height_reg == '0) ? SRC_W'(1) : src_height_reg;
    assign sw16 = {{(SIZE_W-SRC_W){1'b0}}, sw};
    assign sh16 = {{(SIZE_W-SRC_W){1'b0}}, sh};

    // shared multiplier: w*sh first, then h*sw
    assign mul_x = (state_reg == S_MUL_A) ? w_reg : h_reg;
    assign mul_y = (state_reg == S_MUL_A) ? sh : sw;
    assign prod  = NUM_W'(mul_x * mul_y);

    assign both_ge = (h_reg >= sh16) && (w_reg >= sw16);
    assign both_lt = (h_reg <  sh16) && (w_reg <  sw16);
    assign mixed   = !both_ge && !both_lt;

    // stretch on a mixed request divides along the axis chosen by height
    assign sel_b_next = (stretch_reg && mixed) ? (h_reg <= sh16) : (prod_a_reg > prod_b_reg);

    assign div_start = (state_reg == S_CMP);
    assign div_num   = sel_b_next ? prod_b_reg : prod_a_reg;
    assign div_den   = sel_b_next ? sh : sw;

    afp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    assign q16 = sat16(div_quot);

    always_comb
    begin
        if (stretch_reg && !mixed)
        begin
            pw = w_reg;
            ph = h_reg;
        end
        else if (sel_b_reg)
        begin
            pw = q16;
            ph = h_reg;
        end
        else
        begin
            pw = w_reg;
            ph = q16;
        end
    end

    always_comb
    begin
        pic_w_next   = pic_w_reg;
        pic_h_next   = pic_h_reg;
        off_x_next   = off_x_reg;
        off_y_next   = off_y_reg;
        frame_w_next = frame_w_reg;
        frame_h_next = frame_h_reg;
        status_next  = status_reg;
        reenc_next   = 1'b0;
        if (!mode_reg)
        begin
            pic_w_next   = sw16;
            pic_h_next   = sh16;
            frame_w_next = sw16;
            frame_h_next = sh16;
            off_x_next   = '0;
            off_y_next   = '0;
            status_next  = STATUS_NONE;
        end
        else if ((w_reg == sw16) && (h_reg == sh16))
        begin
            pic_w_next   = sw16;
            pic_h_next   = sh16;
            frame_w_next = w_reg;
            frame_h_next = h_reg;
            off_x_next   = '0;
            off_y_next   = '0;
            status_next  = STATUS_NONE;
            reenc_next   = 1'b1;
        end
        else if ((w_reg <= MAX_REQ_WIDTH) && (h_reg <= MAX_REQ_HEIGHT))
        begin
            pic_w_next   = pw;
            pic_h_next   = ph;
            frame_w_next = w_reg;
            frame_h_next = h_reg;
            reenc_next   = 1'b1;
            status_next  = STATUS_ZOOM_IN;
            if (both_ge)
            begin
                if (stretch_reg)
                begin
                    off_x_next = '0;
                    off_y_next = '0;
                end
                else
                begin
                    if (h_reg == ph)
                    begin
                        off_x_next = half_slack(w_reg, pw);
                        off_y_next = '0;
                    end
                    if (w_reg == pw)
                    begin
                        off_x_next = '0;
                        off_y_next = half_slack(h_reg, ph);
                    end
                end
            end
            else if (both_lt)
            begin
                if (stretch_reg)
                begin
                    off_x_next  = '0;
                    off_y_next  = '0;
                    status_next = STATUS_ZOOM_OUT;
                end
                else
                begin
                    if (h_reg == ph)
                        off_x_next = half_slack(w_reg, pw);
                    // coarse match on width in units of 8
                    if (w_reg[SIZE_W-1:3] == pw[SIZE_W-1:3])
                        off_y_next = half_slack(h_reg, ph);
                end
            end
            else if (h_reg <= sh16)
            begin
                off_x_next = half_slack(w_reg, pw);
                off_y_next = '0;
            end
            else
            begin
                off_x_next = '0;
                off_y_next = half_slack(h_reg, ph);
            end
        end
    end

    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            src_width_reg  <= SRC_WIDTH_RESET;
            src_height_reg <= SRC_HEIGHT_RESET;
            stretch_reg    <= 1'b0;
            pic_w_reg      <= '0;
            pic_h_reg      <= '0;
            off_x_reg      <= '0;
            off_y_reg      <= '0;
            frame_w_reg    <= '0;
            frame_h_reg    <= '0;
            status_reg     <= STATUS_NONE;
            reenc_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_W-1:0];
                    CFG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_W-1:0];
                    CFG_STRETCH:    stretch_reg    <= cfg_data[0];
                    default:        ;
                endcase
            end

            if (result.valid && result.ready && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (request.valid)
                        state_reg <= S_MUL_A;
                end
                S_MUL_A:  state_reg <= S_MUL_B;
                S_MUL_B:  state_reg <= S_CMP;
                S_CMP:    state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_stat.done)
                        state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        pic_w_reg     <= pic_w_next;
                        pic_h_reg     <= pic_h_next;
                        off_x_reg     <= off_x_next;
                        off_y_reg     <= off_y_next;
                        frame_w_reg   <= frame_w_next;
                        frame_h_reg   <= frame_h_next;
                        status_reg    <= status_next;
                        reenc_reg     <= reenc_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            mode_reg <= request.mode;
            w_reg    <= request.req_width;
            h_reg    <= request.req_height;
        end
        if (state_reg == S_MUL_A)
            prod_a_reg <= prod;
        if (state_reg == S_MUL_B)
            prod_b_reg <= prod;
        if (state_reg == S_CMP)
            sel_b_reg <= sel_b_next;
    end

    assign request.ready       = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.pic_width    = pic_w_reg;
    assign result.pic_height   = pic_h_reg;
    assign result.offset_x     = $signed(off_x_reg);
    assign result.offset_y     = $signed(off_y_reg);
    assign result.frame_width  = frame_w_reg;
    assign result.frame_height = frame_h_reg;
    assign result.status       = status_reg;
    assign result.reencode     = reenc_reg;

    `AFP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        request.valid && request.ready, !request.ready,
        "request accepted while a request is in flight")
    `AFP_ASSERT_NOW(a_no_accept_in_div, clk, rst_n,
        div_stat.busy, !request.ready,
        "request ready while divider busy")
    `AFP_ASSERT_NOW(a_reencode_frame_limit, clk, rst_n,
        result.valid && result.reencode && (result.status != STATUS_NONE),
        (result.frame_width <= MAX_REQ_WIDTH) && (result.frame_height <= MAX_REQ_HEIGHT),
        "resize result beyond request limit")

endmodule
